@@ rtl/esc_kd_pkg.sv @@
package esc_kd_pkg;

  // Key table geometry
  localparam int KEY_COUNT       = 34;
  localparam int KEY_TEXT_MAX    = 6;
  localparam int KEY_POS_W       = 3;
  localparam int KEY_LEN_W       = 3;
  localparam int SEQ_BUFFER_SIZE = 32;

  localparam logic [7:0] ESC_BYTE = 8'h1B;

  typedef logic [KEY_COUNT-1:0] key_mask_t;

  // Result of one mask step: narrowed mask and the key number on close
  typedef struct packed {
    key_mask_t  mask;
    logic [7:0] key_num;
  } match_t;

  // One result item headed for the output register
  typedef struct packed {
    logic [7:0] code;
    logic       is_key;
  } out_item_t;

  // Length of each key text, in table order
  localparam logic [KEY_LEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd2, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd2, 3'd2,
    3'd2, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5
  };

  // Key texts after ESC, zero padded
  localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_TEXT_MAX] = '{
    '{"[", "A", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "B", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "C", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "1", "~",   8'h00, 8'h00, 8'h00},
    '{"O", "F", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "3", "~",   8'h00, 8'h00, 8'h00},
    '{"[", "5", "~",   8'h00, 8'h00, 8'h00},
    '{"[", "6", "~",   8'h00, 8'h00, 8'h00},
    '{"[", "2", "~",   8'h00, 8'h00, 8'h00},
    '{"O", "Q", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "S", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "1", "6",   "~",   8'h00, 8'h00},
    '{"[", "1", "7",   "~",   8'h00, 8'h00},
    '{"[", "1", "8",   "~",   8'h00, 8'h00},
    '{"[", "1", "9",   "~",   8'h00, 8'h00},
    '{"[", "2", "0",   "~",   8'h00, 8'h00},
    '{"[", "2", "1",   "~",   8'h00, 8'h00},
    '{"[", "2", "4",   "~",   8'h00, 8'h00},
    '{"[", "1", ";",   "5",   "A",   8'h00},
    '{"[", "1", ";",   "5",   "B",   8'h00},
    '{"[", "1", ";",   "5",   "C",   8'h00},
    '{"[", "1", ";",   "5",   "D",   8'h00},
    '{"[", "1", ";",   "5",   "H",   8'h00},
    '{"[", "1", ";",   "5",   "F",   8'h00},
    '{"[", "3", ";",   "5",   "~",   8'h00},
    '{"[", "5", ";",   "5",   "~",   8'h00},
    '{"[", "6", ";",   "5",   "~",   8'h00},
    '{"[", "1", ";",   "2",   "A",   8'h00},
    '{"[", "1", ";",   "2",   "B",   8'h00},
    '{"[", "1", ";",   "2",   "D",   8'h00},
    '{"[", "1", ";",   "2",   "C",   8'h00},
    '{"[", "3", ";",   "2",   "~",   8'h00}
  };

endpackage

@@ rtl/esc_kd_rx_if.sv @@
interface esc_kd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/esc_kd_key_if.sv @@
interface esc_kd_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] code;
  logic       is_key;

  modport source (output valid, output code, output is_key, input ready);
  modport sink (input valid, input code, input is_key, output ready);
endinterface

@@ rtl/esc_kd_match.sv @@
module esc_kd_match #(
  parameter int LEN_W = 5
) (
  input  logic [7:0]             rx_byte_i,
  input  logic [LEN_W-1:0]       pos_i,
  input  logic [LEN_W-1:0]       len_i,
  input  esc_kd_pkg::key_mask_t  mask_i,
  output esc_kd_pkg::match_t     match_o
);

  esc_kd_pkg::key_mask_t next_mask;
  esc_kd_pkg::key_mask_t hit;

  // Narrow the mask: keep keys whose text has this byte at this position
  always_comb begin
    for (int k = 0; k < esc_kd_pkg::KEY_COUNT; k++) begin
      next_mask[k] = mask_i[k] &&
                     (pos_i < LEN_W'(esc_kd_pkg::KEY_LEN[k])) &&
                     (esc_kd_pkg::KEY_TEXT[k][pos_i[esc_kd_pkg::KEY_POS_W-1:0]] == rx_byte_i);
      hit[k] = next_mask[k] && (len_i == LEN_W'(esc_kd_pkg::KEY_LEN[k]));
    end
  end

  // Pick the first full match in table order; zero when none
  always_comb begin
    match_o.mask    = next_mask;
    match_o.key_num = 8'h00;
    for (int k = esc_kd_pkg::KEY_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        match_o.key_num = 8'(k + 1);
      end
    end
  end

endmodule

@@ rtl/esc_kd_out_reg.sv @@
module esc_kd_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  esc_kd_pkg::out_item_t item_i,
  output logic                  ready_o,
  esc_kd_key_if.source          key_o
);

  logic                  valid_q, valid_d;
  esc_kd_pkg::out_item_t item_q;

  // Take a new item when empty or when the held one transfers now
  assign ready_o = !valid_q || key_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (key_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until replaced
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign key_o.valid  = valid_q;
  assign key_o.code   = item_q.code;
  assign key_o.is_key = item_q.is_key;

endmodule

@@ rtl/escape_sequence_key_decoder.sv @@
// Terminal key decoder.
// rx_i carries received terminal bytes; key_o carries one result per
// plain byte or per closed escape sequence. A byte other than ESC outside
// a sequence comes out with is_key 0 and code equal to the byte. ESC opens
// a sequence and gives nothing; the sequence closes on a later byte in
// 0x40..0x7F or at SEQ_BUFFER_SIZE-1 bytes, and then key_o gives is_key 1
// with the key number 1..34, or 0 when no key matched.
// Throughput: one byte per cycle while key_o.ready is high. Latency: a result is valid
// on key_o the cycle after the byte transfer, from a single output
// register fed by the table compare logic.
// Reset clears the sequence state and empties the output register.
// When the receiver stalls, the output register holds its item and
// rx_i.ready stays low until that item transfers.
module escape_sequence_key_decoder #(
  parameter int SEQ_BUFFER_SIZE = esc_kd_pkg::SEQ_BUFFER_SIZE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  esc_kd_rx_if.sink     rx_i,
  esc_kd_key_if.source  key_o
);

  localparam int LEN_W = $clog2(SEQ_BUFFER_SIZE);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(SEQ_BUFFER_SIZE - 1);

  logic                  in_seq_q, in_seq_d;
  logic [LEN_W-1:0]      seq_len_q, seq_len_d;
  esc_kd_pkg::key_mask_t mask_q, mask_d;

  logic                  accept;
  logic                  can_load;
  logic                  load;
  logic [LEN_W-1:0]      new_len;
  logic                  closing;
  esc_kd_pkg::match_t    match;
  esc_kd_pkg::out_item_t item;

  assign rx_i.ready = can_load;
  assign accept     = rx_i.valid && rx_i.ready;
  assign new_len    = seq_len_q + 1'b1;
  assign closing    = ((seq_len_q != '0) && (rx_i.rx_byte[7:6] == 2'b01)) ||
                      (new_len >= LEN_CAP);

  esc_kd_match #(
    .LEN_W (LEN_W)
  ) u_match (
    .rx_byte_i (rx_i.rx_byte),
    .pos_i     (seq_len_q),
    .len_i     (new_len),
    .mask_i    (mask_q),
    .match_o   (match)
  );

  // Advance the sequence state and decide the result for this byte
  always_comb begin
    in_seq_d    = in_seq_q;
    seq_len_d   = seq_len_q;
    mask_d      = mask_q;
    load        = 1'b0;
    item.code   = rx_i.rx_byte;
    item.is_key = 1'b0;
    if (accept) begin
      if (!in_seq_q) begin
        if (rx_i.rx_byte == esc_kd_pkg::ESC_BYTE) begin
          in_seq_d  = 1'b1;
          seq_len_d = '0;
          mask_d    = '1;
        end else begin
          load = 1'b1;
        end
      end else if (closing) begin
        load        = 1'b1;
        item.code   = match.key_num;
        item.is_key = 1'b1;
        in_seq_d    = 1'b0;
        seq_len_d   = '0;
        mask_d      = '1;
      end else begin
        seq_len_d = new_len;
        mask_d    = match.mask;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q  <= 1'b0;
      seq_len_q <= '0;
      mask_q    <= '1;
    end else begin
      in_seq_q  <= in_seq_d;
      seq_len_q <= seq_len_d;
      mask_q    <= mask_d;
    end
  end

  esc_kd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .item_i  (item),
    .ready_o (can_load),
    .key_o   (key_o)
  );

  // Outside a sequence the length counter sits at zero
  a_len_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_seq_q |-> (seq_len_q == '0))
    else $error("sequence length nonzero outside a sequence");

  // The length never reaches the cap while a sequence is open
  a_len_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_len_q < LEN_CAP)
    else $error("sequence length at or beyond cap");

  // ESC outside a sequence opens one and loads no result
  a_esc_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_seq_q && (rx_i.rx_byte == esc_kd_pkg::ESC_BYTE)) |-> !load ##1 in_seq_q)
    else $error("ESC did not open a sequence");

  // A decoded key number stays within the table
  a_key_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_o.valid && key_o.is_key) |-> (key_o.code <= 8'(esc_kd_pkg::KEY_COUNT)))
    else $error("key number out of range");

endmodule
